@@ hw/rtl/wtd_pkg.sv @@
`timescale 1ns / 1ps

package wtd_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int AMOUNT_W = 19;
  localparam int DIST_W   = 18;
  localparam int GUARD    = 12;

  localparam logic [15:0]       GAIN_MUL = 16'd63675;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_CCW  = 3'd0,
    KIND_CW   = 3'd1,
    KIND_FWD  = 3'd2,
    KIND_BWD  = 3'd3,
    KIND_HEAD = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ANGLE,
    ST_DIST,
    ST_ROT,
    ST_DRV,
    ST_HEAD
  } state_e;

  typedef enum logic [1:0] {
    SEL_ROT,
    SEL_DRV,
    SEL_HEAD
  } sel_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic angle;
    logic clip;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic path_open;
    logic step_last;
    logic seg_last;
  } status_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_f(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/wtd_ctrl.sv @@
`timescale 1ns / 1ps

module wtd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             is_first_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wtd_pkg::status_t status_i,
  output wtd_pkg::cmd_t    cmd_o
);

  wtd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.angle  = 1'b0;
    cmd_o.clip   = 1'b0;
    cmd_o.sel    = wtd_pkg::SEL_ROT;
    case (state_q)
      wtd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (is_first_i) begin
            if (is_last_i) begin
              state_d = wtd_pkg::ST_HEAD;
            end
          end else if (status_i.path_open) begin
            state_d = wtd_pkg::ST_CORDIC;
          end
        end
      end
      wtd_pkg::ST_CORDIC: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = wtd_pkg::ST_ANGLE;
        end
      end
      wtd_pkg::ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = wtd_pkg::ST_DIST;
      end
      wtd_pkg::ST_DIST: begin
        cmd_o.clip = 1'b1;
        state_d    = wtd_pkg::ST_ROT;
      end
      wtd_pkg::ST_ROT: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = wtd_pkg::SEL_ROT;
        if (out_ready_i) begin
          state_d = wtd_pkg::ST_DRV;
        end
      end
      wtd_pkg::ST_DRV: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = wtd_pkg::SEL_DRV;
        if (out_ready_i) begin
          state_d = status_i.seg_last ? wtd_pkg::ST_HEAD : wtd_pkg::ST_IDLE;
        end
      end
      wtd_pkg::ST_HEAD: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = wtd_pkg::SEL_HEAD;
        if (out_ready_i) begin
          state_d = wtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wtd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/wtd_dpath.sv @@
`timescale 1ns / 1ps

module wtd_dpath #(
  parameter int COORD_BITS   = wtd_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS   = wtd_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = wtd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic signed [ANGLE_BITS-1:0]         start_heading_i,
  input  logic                                 is_first_i,
  input  logic                                 is_last_i,
  input  wtd_pkg::cmd_t                        cmd_i,
  output wtd_pkg::status_t                     status_o,
  output logic [wtd_pkg::KIND_W-1:0]           kind_o,
  output logic signed [wtd_pkg::AMOUNT_W-1:0]  amount_o,
  output logic                                 last_of_run_o
);

  localparam int DW     = COORD_BITS + 1;
  localparam int XW     = COORD_BITS + 1 + wtd_pkg::GUARD + 2;
  localparam int RSH    = wtd_pkg::GUARD - 8;
  localparam int MW     = XW - RSH;
  localparam int PW     = MW + 16;
  localparam int PBW    = PW - 23;
  localparam int PCW    = (PBW > wtd_pkg::DIST_W + 1) ? PBW : wtd_pkg::DIST_W + 1;
  localparam int AW     = ANGLE_BITS;
  localparam int EXT_W  = (AW + 1 > wtd_pkg::AMOUNT_W) ? AW + 1 : wtd_pkg::AMOUNT_W;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam logic signed [AW-1:0]     QTR      = AW'(1) << (AW - 2);
  localparam logic [31:0]              ANG_RND  = 32'd1 << (31 - AW);
  localparam logic signed [XW-1:0]     X_RND    = XW'(1) << (RSH - 1);
  localparam logic [PW:0]              P_RND    = (PW + 1)'(1) << 23;
  localparam logic [STEP_W-1:0]        STEP_END = STEP_W'(CORDIC_STEPS - 1);

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [AW-1:0]         heading_q;
  logic                         open_q;
  logic [STEP_W-1:0]            cnt_q;
  logic                         last_q;
  logic                         zero_q;
  logic signed [XW-1:0]         x_q, y_q;
  logic [31:0]                  z_q;
  logic signed [AW-1:0]         rot_q;
  logic                         fwd_q;
  logic [PW-1:0]                prod_q;
  logic [wtd_pkg::DIST_W-1:0]   dist_q;

  logic signed [DW-1:0] dx, dy;
  logic signed [XW-1:0] x_init, y_init;
  logic                 seg_take;

  assign dx       = DW'(point_x_i) - DW'(prev_x_q);
  assign dy       = DW'(point_y_i) - DW'(prev_y_q);
  assign x_init   = XW'(dx) <<< wtd_pkg::GUARD;
  assign y_init   = XW'(dy) <<< wtd_pkg::GUARD;
  assign seg_take = cmd_i.accept && !is_first_i && open_q;

  logic signed [XW-1:0] xs, ys;
  logic [31:0]          atan_v;

  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = wtd_pkg::atan_f(5'(cnt_q));

  logic [31:0]          z_rnd;
  logic signed [AW-1:0] target, rot_raw;
  logic                 flip;
  logic signed [XW-1:0] x_rnd;
  logic [MW-1:0]        mag;

  assign z_rnd   = z_q + ANG_RND;
  assign target  = z_rnd[31 -: AW];
  assign rot_raw = target - heading_q;
  assign flip    = !last_q && ((rot_raw > QTR) || (rot_raw < -QTR));
  assign x_rnd   = x_q + X_RND;
  assign mag     = x_rnd[XW-1:RSH];

  logic [PW:0]    psum;
  logic [PCW-1:0] p_ext;

  assign psum  = (PW + 1)'(prod_q) + P_RND;
  assign p_ext = PCW'(psum[PW:24]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      heading_q <= '0;
      open_q    <= 1'b0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= is_last_i;
        if (is_first_i) begin
          prev_x_q  <= point_x_i;
          prev_y_q  <= point_y_i;
          heading_q <= start_heading_i;
          open_q    <= !is_last_i;
        end else if (open_q) begin
          prev_x_q <= point_x_i;
          prev_y_q <= point_y_i;
          open_q   <= !is_last_i;
          cnt_q    <= '0;
        end
      end
      if (cmd_i.step) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end
      if (cmd_i.angle && !zero_q) begin
        heading_q <= flip ? {~target[AW-1], target[AW-2:0]} : target;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_take) begin
      zero_q <= (dx == '0) && (dy == '0);
      x_q    <= dx[DW-1] ? -x_init : x_init;
      y_q    <= dx[DW-1] ? -y_init : y_init;
      z_q    <= dx[DW-1] ? 32'h8000_0000 : 32'h0;
    end else if (cmd_i.step) begin
      if (!y_q[XW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
    if (cmd_i.angle) begin
      if (zero_q) begin
        rot_q  <= '0;
        fwd_q  <= 1'b1;
        prod_q <= '0;
      end else begin
        rot_q  <= flip ? {~rot_raw[AW-1], rot_raw[AW-2:0]} : rot_raw;
        fwd_q  <= !flip;
        prod_q <= PW'(mag) * PW'(wtd_pkg::GAIN_MUL);
      end
    end
    if (cmd_i.clip) begin
      dist_q <= (p_ext > PCW'(wtd_pkg::DIST_MAX)) ? wtd_pkg::DIST_MAX
                                                  : p_ext[wtd_pkg::DIST_W-1:0];
    end
  end

  assign status_o.path_open = open_q;
  assign status_o.step_last = (cnt_q == STEP_END);
  assign status_o.seg_last  = last_q;

  logic signed [EXT_W-1:0] rot_ext, rot_neg, head_ext;
  logic                    rot_pos;

  assign rot_ext  = EXT_W'(rot_q);
  assign rot_neg  = -rot_ext;
  assign head_ext = EXT_W'(heading_q);
  assign rot_pos  = rot_q > 0;

  always_comb begin
    kind_o        = wtd_pkg::KIND_HEAD;
    amount_o      = head_ext[wtd_pkg::AMOUNT_W-1:0];
    last_of_run_o = 1'b1;
    case (cmd_i.sel)
      wtd_pkg::SEL_ROT: begin
        kind_o        = rot_pos ? wtd_pkg::KIND_CCW : wtd_pkg::KIND_CW;
        amount_o      = rot_pos ? rot_ext[wtd_pkg::AMOUNT_W-1:0]
                                : rot_neg[wtd_pkg::AMOUNT_W-1:0];
        last_of_run_o = 1'b0;
      end
      wtd_pkg::SEL_DRV: begin
        kind_o        = fwd_q ? wtd_pkg::KIND_FWD : wtd_pkg::KIND_BWD;
        amount_o      = wtd_pkg::AMOUNT_W'(dist_q);
        last_of_run_o = !last_q;
      end
      wtd_pkg::SEL_HEAD: begin
        kind_o        = wtd_pkg::KIND_HEAD;
        amount_o      = head_ext[wtd_pkg::AMOUNT_W-1:0];
        last_of_run_o = 1'b1;
      end
      default: begin
        kind_o        = wtd_pkg::KIND_HEAD;
        amount_o      = head_ext[wtd_pkg::AMOUNT_W-1:0];
        last_of_run_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/waypoint_to_turn_and_drive.sv @@
`timescale 1ns / 1ps

// Waypoint to turn-and-drive converter.
// Input channel (in_valid_i/in_ready_o): one waypoint per request; is_first_i
// starts a path and carries the start heading, is_last_i ends it.
// Output channel (out_valid_o/out_ready_i): commands kind_o/amount_o, with
// last_of_run_o marking the final result of one waypoint.
// A first waypoint gives no result (or only the heading when it is also
// last). Each later waypoint gives rotate and drive, plus the final heading
// on the last one. Waypoints with no open path are dropped.
// A segment is accepted, runs through CORDIC_STEPS iterations of the shared
// CORDIC stage, then one angle/multiply step and one saturation step, then
// its results go out one per cycle while out_ready_i is high. The block takes
// one waypoint at a time; in_ready_o is high only while no work is pending.
// A stalled receiver holds the current result on the ports until taken.
// Reset clears the path state; no path is open afterward.

module waypoint_to_turn_and_drive #(
  parameter int COORD_BITS   = wtd_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS   = wtd_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = wtd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic signed [ANGLE_BITS-1:0]        start_heading_i,
  input  logic                                is_first_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wtd_pkg::KIND_W-1:0]          kind_o,
  output logic signed [wtd_pkg::AMOUNT_W-1:0] amount_o,
  output logic                                last_of_run_o
);

  wtd_pkg::cmd_t    cmd;
  wtd_pkg::status_t status;

  wtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .is_first_i  (is_first_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wtd_dpath #(
    .COORD_BITS   (COORD_BITS),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .start_heading_i (start_heading_i),
    .is_first_i      (is_first_i),
    .is_last_i       (is_last_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_o          (kind_o),
    .amount_o        (amount_o),
    .last_of_run_o   (last_of_run_o)
  );

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_head_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == wtd_pkg::KIND_HEAD) |-> last_of_run_o)
    else $error("final heading not marked as last");

  a_rot_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == wtd_pkg::KIND_CCW) || (kind_o == wtd_pkg::KIND_CW))
    |-> !last_of_run_o)
    else $error("rotate marked as last");

  a_drive_then_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o &&
    ((kind_o == wtd_pkg::KIND_FWD) || (kind_o == wtd_pkg::KIND_BWD))
    |=> out_valid_o && (kind_o == wtd_pkg::KIND_HEAD))
    else $error("final heading missing after last drive");

endmodule
